/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules of the UTF-8 to UTF-16 copy block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/utu_pkg.sv */
// Shared types, constants and helper functions of the UTF-8 to UTF-16 copy block.
`default_nettype none

package utu_pkg;

   // Width of the length arithmetic; sets where remaining_bytes saturates.
   localparam int LENGTH_WIDTH = 32;
   localparam logic [32:0] LEN_LIMIT = (LENGTH_WIDTH >= 32) ? 33'h0_FFFF_FFFF :
                                       ((33'd1 << LENGTH_WIDTH) - 33'd1);

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int SLOT_COUNT     = 4;

   localparam logic [15:0] UNIT_FILLER = 16'h0058;
   localparam logic [15:0] UNIT_NUL    = 16'h0000;
   localparam logic [15:0] SURR_HIGH   = 16'hD800;
   localparam logic [15:0] SURR_LOW    = 16'hDC00;
   localparam logic [31:0] SUPP_BASE   = 32'h0001_0000;

   typedef enum logic [1:0] {
      REG_SKIP    = 2'd0,
      REG_BUFFER  = 2'd1,
      REG_LENIENT = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_TERM    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef struct packed {
      logic [31:0] skip_bytes;
      logic [15:0] dest_size;
      logic        lenient_mode;
   } cfg_type;

   // All result words caused by one source word, in delivery order.
   typedef struct packed {
      logic [2:0]                   count;
      logic [SLOT_COUNT-1:0][1:0]   kind;
      logic [SLOT_COUNT-1:0][15:0]  unit;
      logic [31:0]                  remaining_bytes;
      logic [14:0]                  copied_units;
      logic                         truncated;
   } bundle_type;

   // Sequence length announced by a lead byte; a stray byte counts as one.
   function automatic logic [2:0] lead_length(logic [7:0] b);
      logic [2:0] len;
      if (b[7] == 1'b0)            len = 3'd1;
      else if (b[7:5] == 3'b110)   len = 3'd2;
      else if (b[7:4] == 4'b1110)  len = 3'd3;
      else if (b[7:3] == 5'b11110) len = 3'd4;
      else                         len = 3'd1;
      return len;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/utu_csr.sv */
// Configuration register file with its APB-style access port.
`default_nettype none

module utu_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [utu_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   output utu_pkg::cfg_type                    cfg
);

   utu_pkg::cfg_type cfg_ff;
   utu_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (utu_pkg::reg_index_type'(csr_paddr[3:2]))
            utu_pkg::REG_SKIP:    cfg_in.skip_bytes   = csr_pwdata;
            utu_pkg::REG_BUFFER:  cfg_in.dest_size    = csr_pwdata[15:0];
            utu_pkg::REG_LENIENT: cfg_in.lenient_mode = csr_pwdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (utu_pkg::reg_index_type'(csr_paddr[3:2]))
         utu_pkg::REG_SKIP:    csr_prdata = cfg_ff.skip_bytes;
         utu_pkg::REG_BUFFER:  csr_prdata = {16'd0, cfg_ff.dest_size};
         utu_pkg::REG_LENIENT: csr_prdata = {31'd0, cfg_ff.lenient_mode};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/utu_core.sv */
// Input register, per-string decode state and the single-pass transcode logic.
`default_nettype none

module utu_core (
   input  logic                clock,
   input  logic                reset,
   input  utu_pkg::cfg_type    cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tuser,
   input  logic                req_tlast,
   input  logic                out_ready,
   output logic                bundle_load,
   output utu_pkg::bundle_type bundle
);

`include "assert_macros.svh"

   // Input register.
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_bvalid_ff;
   logic        in_end_ff;

   // Per-string state.
   logic [31:0] pos_ff,     pos_in;
   logic [20:0] val_ff,     val_in;
   logic [2:0]  exp_ff,     exp_in;
   logic [2:0]  cnt_ff,     cnt_in;
   logic [7:0]  lead_ff,    lead_in;
   logic [14:0] written_ff, written_in;
   logic [31:0] avail_ff,   avail_in;
   logic        stopped_ff, stopped_in;

   logic        advance;
   logic        keep;
   logic [31:0] pos_s;
   logic [2:0]  len;
   logic [7:0]  lead_s;
   logic [20:0] val_s;
   logic [2:0]  exp_s;
   logic [2:0]  cnt_s;
   logic        fin;
   logic [2:0]  fin_len;
   logic [7:0]  fin_lead;
   logic [20:0] fin_val;
   logic [20:0] cp;
   logic [1:0]  units;
   logic [32:0] avail_sum;
   logic [31:0] avail_f;
   logic [14:0] written_f;
   logic        stopped_f;
   logic        buf_ok;
   logic [14:0] cap;
   logic [15:0] need;
   logic        emit;
   logic [31:0] v;
   logic [15:0] unit_hi;
   logic [15:0] unit_lo;
   logic [32:0] rem_full;
   logic [2:0]  n;

   function automatic logic [20:0] code_point(logic [2:0] l, logic [7:0] ld, logic [20:0] vl);
      logic [20:0] r;
      case (l)
         3'd2:    r = {10'd0, ld[4:0], vl[5:0]};
         3'd3:    r = {5'd0, ld[3:0], vl[11:0]};
         3'd4:    r = {ld[2:0], vl[17:0]};
         default: r = {13'd0, ld};
      endcase
      return r;
   endfunction

   assign advance     = in_valid_ff & ((bundle.count == 3'd0) | out_ready);
   assign req_tready  = ~in_valid_ff | advance;
   assign bundle_load = advance & (bundle.count != 3'd0);

   // Byte handling: open a sequence on a lead byte or extend the open one.
   always_comb begin
      keep     = in_bvalid_ff & (pos_ff >= cfg.skip_bytes);
      pos_s    = (in_bvalid_ff && pos_ff != 32'hFFFF_FFFF) ? pos_ff + 32'd1 : pos_ff;
      len      = utu_pkg::lead_length(in_byte_ff);
      lead_s   = lead_ff;
      val_s    = val_ff;
      exp_s    = exp_ff;
      cnt_s    = cnt_ff;
      fin      = 1'b0;
      fin_len  = 3'd0;
      fin_lead = lead_ff;
      fin_val  = val_ff;
      if (keep) begin
         if (exp_ff == 3'd0) begin
            lead_s = in_byte_ff;
            val_s  = 21'd0;
            cnt_s  = 3'd1;
            if (len == 3'd1) begin
               fin      = 1'b1;
               fin_len  = 3'd1;
               fin_lead = in_byte_ff;
               fin_val  = 21'd0;
            end else begin
               exp_s = len;
            end
         end else begin
            val_s = {val_ff[14:0], in_byte_ff[5:0]};
            cnt_s = cnt_ff + 3'd1;
            if (cnt_s >= exp_ff) begin
               fin      = 1'b1;
               fin_len  = exp_ff;
               fin_lead = lead_ff;
               fin_val  = val_s;
            end
         end
      end
      // A sequence still open at end of string closes at its received length.
      if (in_end_ff && !fin && exp_s != 3'd0) begin
         fin      = 1'b1;
         fin_len  = cnt_s;
         fin_lead = lead_s;
         fin_val  = val_s;
      end
      if (fin) begin
         exp_s = 3'd0;
         cnt_s = 3'd0;
         val_s = 21'd0;
      end
   end

   // Finished sequence: count its units and copy them while they fit.
   always_comb begin
      cp        = code_point(fin_len, fin_lead, fin_val);
      units     = (fin_len == 3'd4) ? 2'd2 : 2'd1;
      avail_sum = {1'b0, avail_ff} + {31'd0, units};
      avail_f   = avail_ff;
      if (fin) begin
         avail_f = avail_sum[32] ? 32'hFFFF_FFFF : avail_sum[31:0];
      end
      buf_ok    = |cfg.dest_size[15:1];
      cap       = cfg.dest_size[15:1] - 15'd1;
      need      = {1'b0, written_ff} + {14'd0, units};
      emit      = 1'b0;
      written_f = written_ff;
      stopped_f = stopped_ff;
      if (fin && buf_ok && !stopped_ff) begin
         if (need > {1'b0, cap}) begin
            stopped_f = 1'b1;
         end else begin
            emit      = 1'b1;
            written_f = need[14:0];
         end
      end
      v       = {11'd0, cp} - utu_pkg::SUPP_BASE;
      unit_hi = utu_pkg::SURR_HIGH + v[25:10];
      unit_lo = utu_pkg::SURR_LOW + {6'd0, v[9:0]};
   end

   // Result words of this source word, packed in delivery order.
   always_comb begin
      bundle   = '0;
      n        = 3'd0;
      rem_full = {avail_f, 1'b0};
      if (emit) begin
         bundle.kind[n[1:0]] = utu_pkg::KIND_DATA;
         bundle.unit[n[1:0]] = (units == 2'd2) ? unit_hi : cp[15:0];
         n = n + 3'd1;
         if (units == 2'd2) begin
            bundle.kind[n[1:0]] = utu_pkg::KIND_DATA;
            bundle.unit[n[1:0]] = unit_lo;
            n = n + 3'd1;
         end
      end
      if (in_end_ff) begin
         if (buf_ok) begin
            bundle.kind[n[1:0]] = utu_pkg::KIND_TERM;
            bundle.unit[n[1:0]] = cfg.lenient_mode ? utu_pkg::UNIT_FILLER : utu_pkg::UNIT_NUL;
            n = n + 3'd1;
         end
         bundle.kind[n[1:0]]    = utu_pkg::KIND_SUMMARY;
         bundle.unit[n[1:0]]    = 16'd0;
         n = n + 3'd1;
         bundle.remaining_bytes = (rem_full > utu_pkg::LEN_LIMIT) ?
                                  utu_pkg::LEN_LIMIT[31:0] : rem_full[31:0];
         bundle.copied_units    = written_f;
         bundle.truncated       = ({17'd0, written_f} < avail_f);
      end
      bundle.count = n;
   end

   // End of string returns all per-string state to zero.
   always_comb begin
      if (in_end_ff) begin
         pos_in     = 32'd0;
         val_in     = 21'd0;
         exp_in     = 3'd0;
         cnt_in     = 3'd0;
         lead_in    = 8'd0;
         written_in = 15'd0;
         avail_in   = 32'd0;
         stopped_in = 1'b0;
      end else begin
         pos_in     = pos_s;
         val_in     = val_s;
         exp_in     = exp_s;
         cnt_in     = cnt_s;
         lead_in    = lead_s;
         written_in = written_f;
         avail_in   = avail_f;
         stopped_in = stopped_f;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff   <= req_tdata;
         in_bvalid_ff <= req_tuser;
         in_end_ff    <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 32'd0;
         val_ff     <= 21'd0;
         exp_ff     <= 3'd0;
         cnt_ff     <= 3'd0;
         lead_ff    <= 8'd0;
         written_ff <= 15'd0;
         avail_ff   <= 32'd0;
         stopped_ff <= 1'b0;
      end else if (advance) begin
         pos_ff     <= pos_in;
         val_ff     <= val_in;
         exp_ff     <= exp_in;
         cnt_ff     <= cnt_in;
         lead_ff    <= lead_in;
         written_ff <= written_in;
         avail_ff   <= avail_in;
         stopped_ff <= stopped_in;
      end
   end

   `ASSERT_IMPLY(a_seq_bounds, clock, reset, exp_ff != 3'd0, cnt_ff != 3'd0 && cnt_ff < exp_ff)
   `ASSERT_IMPLY(a_written_le_avail, clock, reset, 1'b1, {17'd0, written_ff} <= avail_ff)
   `ASSERT_NEXT(a_end_clears, clock, reset, advance && in_end_ff, pos_ff == 32'd0 && exp_ff == 3'd0 && avail_ff == 32'd0)

endmodule

`default_nettype wire

/* hw/rtl/utu_out.sv */
// Result register that hands the words of one bundle out one per cycle while rsp_tready is high.
`default_nettype none

module utu_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                bundle_load,
   input  utu_pkg::bundle_type bundle,
   output logic                out_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [71:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);

`include "assert_macros.svh"

   utu_pkg::bundle_type bundle_ff;
   logic                busy_ff, busy_in;
   logic [1:0]          idx_ff,  idx_in;
   logic                take;
   logic                last_take;
   logic                is_sum;
   logic [15:0]         unit;

   assign take      = busy_ff & rsp_tready;
   assign last_take = take & (({1'b0, idx_ff} + 3'd1) == bundle_ff.count);
   assign out_ready = ~busy_ff | last_take;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (bundle_load) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (last_take) begin
         busy_in = 1'b0;
      end else if (take) begin
         idx_in  = idx_ff + 2'd1;
      end
   end

   // Summary fields read as zero on every word but the summary.
   always_comb begin
      is_sum     = (bundle_ff.kind[idx_ff] == utu_pkg::KIND_SUMMARY);
      unit       = bundle_ff.unit[idx_ff];
      rsp_tvalid = busy_ff;
      rsp_tuser  = bundle_ff.kind[idx_ff];
      rsp_tlast  = busy_ff & is_sum;
      if (is_sum) begin
         rsp_tdata = {7'd0, bundle_ff.truncated, bundle_ff.truncated,
                      bundle_ff.copied_units, bundle_ff.remaining_bytes, unit};
      end else begin
         rsp_tdata = {56'd0, unit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle_load) begin
         bundle_ff <= bundle;
      end
   end

   `ASSERT_IMPLY(a_busy_count, clock, reset, busy_ff, bundle_ff.count != 3'd0 && {1'b0, idx_ff} < bundle_ff.count)
   `ASSERT_IMPLY(a_summary_last, clock, reset, rsp_tlast, ({1'b0, idx_ff} + 3'd1) == bundle_ff.count)

endmodule

`default_nettype wire

/* hw/rtl/utf8_to_utf16_bounded_copy.sv */
// Top level of the UTF-8 to UTF-16 transcoder with bounded copy into a unit buffer.
`default_nettype none

// Channel   Direction  Word contents
// req_      in         tdata[7:0] data_byte, tuser byte_valid, tlast end_of_string
// rsp_      out        tdata unit/summary fields, tuser item_kind, tlast last_result
// csr_      in/out     APB-style registers: 0x0 skip_bytes, 0x4 target size in bytes,
//                      0x8 lenient_mode
//
// A source word goes from the input register through the transcode logic into the
// result register as a bundle of zero to four result words.
// The result register hands out one word per cycle while rsp_tready is high, and a
// word with no results moves on without entering it; single-word traffic runs back
// to back. Reset is synchronous and clears the channels, string state and registers.
// A stall on rsp_tready holds the bundle, and a waiting word with results drops req_tready.
module utf8_to_utf16_bounded_copy (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   // data_byte [7:0]
   input  logic [7:0]                          req_tdata,
   // byte_valid [0]
   input  logic                                req_tuser,
   input  logic                                req_tlast,

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // unit_value [15:0], remaining_bytes [47:16], copied_units [62:48],
   // truncated [63], truncated copy [64], zero fill [71:65]
   output logic [71:0]                         rsp_tdata,
   // item_kind [1:0]
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [utu_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   utu_pkg::cfg_type    cfg;
   utu_pkg::bundle_type bundle;
   logic                bundle_load;
   logic                out_ready;

   // Register file; the user changes configuration only while the block is idle (unenforced).
   utu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequence grouping, surrogate split, bounded copy and the end-of-string summary.
   utu_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .out_ready   (out_ready),
      .bundle_load (bundle_load),
      .bundle      (bundle)
   );

   // Result register that serializes each bundle onto the rsp_ channel.
   utu_out u_out (
      .clock       (clock),
      .reset       (reset),
      .bundle_load (bundle_load),
      .bundle      (bundle),
      .out_ready   (out_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire
